// ----- src/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Internal widths follow from the geometry.
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELL_W = $clog2(CELL_COUNT);

    // Port field widths.
    localparam int OP_W     = 2;
    localparam int IN_COL_W = 7;
    localparam int IN_ROW_W = 5;
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE       = 8'd10;
    localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT  = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_e_t;

    // One classified command as it travels through the queue.
    typedef struct packed {
        op_e_t              op;
        logic               use_pos;
        logic               is_newline;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [DATA_W-1:0]  cell_word;
    } cmd_t;

    // Clamp a column field to the last column.
    function automatic logic [COL_W-1:0] clamp_col(input logic [IN_COL_W-1:0] c);
        if (32'(c) > COLUMNS - 1) begin
            return COL_W'(COLUMNS - 1);
        end
        return COL_W'(c);
    endfunction

    // Clamp a row field to the last row.
    function automatic logic [ROW_W-1:0] clamp_row(input logic [IN_ROW_W-1:0] r);
        if (32'(r) > ROWS - 1) begin
            return ROW_W'(ROWS - 1);
        end
        return ROW_W'(r);
    endfunction

    // Linear cell index of a row and column.
    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return CELL_W'(32'(r) * COLUMNS + 32'(c));
    endfunction

endpackage

// ----- src/text_console_writer.sv -----
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      operation, use_position, column, row,
//                                             char_code, attribute
// m_        out        m_valid / m_ready      cursor_column, cursor_row, cell_char,
//                                             cell_attribute, scrolled
// cfg_      in         cfg_valid / cfg_ready  default attribute byte (cfg_wdata)
//
// Put, set cursor and the unused code load the result straight from the idle state; a
// read passes through a read state, since the screen memory has a registered read port.
// A put that wraps or takes a newline on the bottom row scrolls: the memory copies one
// cell per cycle through its registered read port and a write-back stage.
// After reset a clearing pass zeroes every cell of the screen; s_ready stays low
// meanwhile, while configuration writes are taken.
// A two-entry command queue lets the input side keep accepting while the back end is
// busy or the result waits in the output register.
module text_console_writer import tcw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic                 s_use_position,
    input  logic [IN_COL_W-1:0]  s_column,
    input  logic [IN_ROW_W-1:0]  s_row,
    input  logic [BYTE_W-1:0]    s_char_code,
    input  logic [BYTE_W-1:0]    s_attribute,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IN_COL_W-1:0]  m_cursor_column,
    output logic [IN_ROW_W-1:0]  m_cursor_row,
    output logic [BYTE_W-1:0]    m_cell_char,
    output logic [BYTE_W-1:0]    m_cell_attribute,
    output logic                 m_scrolled,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_wdata
);

    logic clear_busy;
    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    // Front end: configuration register and command classification.
    tcw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_use_position (s_use_position),
        .s_column       (s_column),
        .s_row          (s_row),
        .s_char_code    (s_char_code),
        .s_attribute    (s_attribute),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata),
        .cmd_valid      (fq_valid),
        .cmd_ready      (fq_ready),
        .cmd            (fq_cmd),
        .clear_busy     (clear_busy)
    );

    // Command queue between the two halves.
    tcw_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // Back end: screen memory, cursor and scroll engine.
    tcw_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (qb_valid),
        .cmd_ready        (qb_ready),
        .cmd              (qb_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_column  (m_cursor_column),
        .m_cursor_row     (m_cursor_row),
        .m_cell_char      (m_cell_char),
        .m_cell_attribute (m_cell_attribute),
        .m_scrolled       (m_scrolled),
        .clear_busy       (clear_busy)
    );

endmodule

// ----- src/tcw_front.sv -----
module tcw_front import tcw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic                 s_use_position,
    input  logic [IN_COL_W-1:0]  s_column,
    input  logic [IN_ROW_W-1:0]  s_row,
    input  logic [BYTE_W-1:0]    s_char_code,
    input  logic [BYTE_W-1:0]    s_attribute,
    // Configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    // Toward the command queue
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd,
    // Back end still clearing the screen
    input  logic                 clear_busy
);

    logic [BYTE_W-1:0] default_attr_reg;
    logic [BYTE_W-1:0] default_attr_next;
    logic [BYTE_W-1:0] attr_sel;

    // The register is always ready to take a write.
    assign cfg_ready = 1'b1;

    always_comb begin
        default_attr_next = default_attr_reg;
        if (cfg_valid) begin
            default_attr_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_attr_reg <= DEFAULT_ATTR_RESET;
        end else begin
            default_attr_reg <= default_attr_next;
        end
    end

    // A zero attribute picks the default one.
    assign attr_sel = (s_attribute == '0) ? default_attr_reg : s_attribute;

    // Classify the transaction and clamp its position.
    always_comb begin
        cmd.op         = op_e_t'(s_operation);
        cmd.use_pos    = s_use_position;
        cmd.is_newline = (s_char_code == NEWLINE_CODE);
        cmd.col        = clamp_col(s_column);
        cmd.row        = clamp_row(s_row);
        cmd.cell_word  = {attr_sel, s_char_code};
    end

    // No transaction is taken while the screen is being cleared.
    assign cmd_valid = s_valid && !clear_busy;
    assign s_ready   = cmd_ready && !clear_busy;

endmodule

// ----- src/tcw_cmd_fifo.sv -----
module tcw_cmd_fifo import tcw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (32'(count_reg) < QUEUE_DEPTH);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- src/tcw_back.sv -----
module tcw_back import tcw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // From the command queue
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IN_COL_W-1:0]  m_cursor_column,
    output logic [IN_ROW_W-1:0]  m_cursor_row,
    output logic [BYTE_W-1:0]    m_cell_char,
    output logic [BYTE_W-1:0]    m_cell_attribute,
    output logic                 m_scrolled,
    // Clearing pass after reset in progress
    output logic                 clear_busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CELL_W-1:0]   idx_reg, idx_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic                wb_valid_reg, wb_valid_next;
    logic                wb_copy_reg, wb_copy_next;
    logic [CELL_W-1:0]   wb_idx_reg, wb_idx_next;
    logic                m_valid_reg, m_valid_next;
    logic [IN_COL_W-1:0] m_col_reg, m_col_next;
    logic [IN_ROW_W-1:0] m_row_reg, m_row_next;
    logic [BYTE_W-1:0]   m_char_reg, m_char_next;
    logic [BYTE_W-1:0]   m_attr_reg, m_attr_next;
    logic                m_scr_reg, m_scr_next;

    // Screen memory: one write and one registered read per cycle.
    logic [DATA_W-1:0]   screen_mem [CELL_COUNT];
    logic [DATA_W-1:0]   rdata_reg;
    logic                mem_we, mem_re;
    logic [CELL_W-1:0]   mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata;

    logic                out_free;
    logic                load_out;
    logic [BYTE_W-1:0]   load_char, load_attr;
    logic                load_scr;
    logic [COL_W-1:0]    tgt_col;
    logic [ROW_W-1:0]    tgt_row;
    logic                row_wrap;

    assign out_free   = !m_valid_reg || m_ready;
    assign clear_busy = (state_reg == ST_CLEAR);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        wb_valid_next = 1'b0;
        wb_copy_next  = wb_copy_reg;
        wb_idx_next   = wb_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_col_next    = m_col_reg;
        m_row_next    = m_row_reg;
        m_char_next   = m_char_reg;
        m_attr_next   = m_attr_reg;
        m_scr_next    = m_scr_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        cmd_ready     = 1'b0;
        load_out      = 1'b0;
        load_char     = '0;
        load_attr     = '0;
        load_scr      = 1'b0;
        tgt_col       = cmd.use_pos ? cmd.col : cur_col_reg;
        tgt_row       = cmd.use_pos ? cmd.row : cur_row_reg;
        row_wrap      = cmd.is_newline || (32'(tgt_col) == COLUMNS - 1);

        unique case (state_reg)
            // Zero every cell once after reset.
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (32'(idx_reg) == CELL_COUNT - 1) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Take one command when the output register can receive its result.
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    unique case (cmd.op)
                        OP_PUT: begin
                            if (!cmd.is_newline) begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(tgt_row, tgt_col);
                                mem_wdata = cmd.cell_word;
                            end
                            if (!row_wrap) begin
                                cur_col_next = tgt_col + 1'b1;
                                cur_row_next = tgt_row;
                                load_out     = 1'b1;
                            end else if (32'(tgt_row) == ROWS - 1) begin
                                cur_col_next = '0;
                                cur_row_next = ROW_W'(ROWS - 1);
                                idx_next     = '0;
                                state_next   = ST_SCROLL;
                            end else begin
                                cur_col_next = '0;
                                cur_row_next = tgt_row + 1'b1;
                                load_out     = 1'b1;
                            end
                        end
                        OP_SET: begin
                            cur_col_next = cmd.col;
                            cur_row_next = cmd.row;
                            load_out     = 1'b1;
                        end
                        OP_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = cell_addr(cmd.row, cmd.col);
                            state_next = ST_READ;
                        end
                        OP_NONE: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            // Read data is back from the memory.
            ST_READ: begin
                load_out   = 1'b1;
                load_char  = rdata_reg[BYTE_W-1:0];
                load_attr  = rdata_reg[DATA_W-1:BYTE_W];
                state_next = ST_IDLE;
            end

            // Copy each cell from one row below, then zero the bottom row.
            ST_SCROLL: begin
                if (32'(idx_reg) < CELL_COUNT - COLUMNS) begin
                    mem_re       = 1'b1;
                    mem_raddr    = CELL_W'(32'(idx_reg) + COLUMNS);
                    wb_copy_next = 1'b1;
                end else begin
                    wb_copy_next = 1'b0;
                end
                wb_valid_next = 1'b1;
                wb_idx_next   = idx_reg;
                if (32'(idx_reg) == CELL_COUNT - 1) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Last write of the scroll goes out with the result.
            ST_DRAIN: begin
                load_out   = 1'b1;
                load_scr   = 1'b1;
                state_next = ST_IDLE;
            end
        endcase

        // Write-back stage of the scroll copy.
        if (wb_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wb_idx_reg;
            mem_wdata = wb_copy_reg ? rdata_reg : '0;
        end

        // Result register load.
        if (load_out) begin
            m_valid_next = 1'b1;
            m_col_next   = IN_COL_W'(cur_col_next);
            m_row_next   = IN_ROW_W'(cur_row_next);
            m_char_next  = load_char;
            m_attr_next  = load_attr;
            m_scr_next   = load_scr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        wb_copy_reg <= wb_copy_next;
        wb_idx_reg  <= wb_idx_next;
        m_col_reg   <= m_col_next;
        m_row_reg   <= m_row_next;
        m_char_reg  <= m_char_next;
        m_attr_reg  <= m_attr_next;
        m_scr_reg   <= m_scr_next;
    end

    // Screen memory ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cursor_column  = m_col_reg;
    assign m_cursor_row     = m_row_reg;
    assign m_cell_char      = m_char_reg;
    assign m_cell_attribute = m_attr_reg;
    assign m_scrolled       = m_scr_reg;

    // No command leaves the queue during the clearing pass.
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !cmd_ready)
        else $error("command taken during screen clear");

    // A command is only taken when its result has a place to go.
    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |-> (!m_valid_reg || m_ready))
        else $error("command taken while result register is blocked");

    // The cursor always stays on the screen.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_col_reg) <= COLUMNS - 1) && (32'(cur_row_reg) <= ROWS - 1))
        else $error("cursor left the screen");

    // A scroll leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_scr_reg) |-> ((cur_col_reg == '0) &&
                                        (32'(cur_row_reg) == ROWS - 1)))
        else $error("scroll result with cursor off the bottom row start");

endmodule
